// File: hdl/abs_pkg.sv
// ---------------------------------------------------------------------------
// abs_pkg
// Shared types for the averaged background subtraction block: pixel and
// mask payloads, the per-frame phase and the configuration register indexes.
// ---------------------------------------------------------------------------
package abs_pkg;

    typedef struct packed {
        logic [7:0] first_channel;
        logic [7:0] third_channel;
        logic       frame_end;
    } t_pixel_in;

    typedef struct packed {
        logic foreground;
        logic mask_valid;
        logic frame_last;
    } t_mask_out;

    typedef enum logic [1:0] {
        PH_LEARN,
        PH_BUILD,
        PH_DETECT
    } t_phase;

    localparam int unsigned CFG_INDEX_W = 1;
    localparam int unsigned CFG_DATA_W  = 9;

    localparam logic [CFG_INDEX_W-1:0] CFG_FIRST_THRESHOLD = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_THIRD_THRESHOLD = 1'b1;

    localparam logic [CFG_DATA_W-1:0] THRESHOLD_RESET = 9'd8;

    localparam int unsigned SUM_W  = 12;
    localparam int unsigned WORD_W = 2 * SUM_W;

endpackage

// File: hdl/averaged_background_subtraction.sv
// ---------------------------------------------------------------------------
// averaged_background_subtraction
// Path: a pixel's result is registered in stage 1, then held in the result
// queue until taken. Throughput: one pixel per clock while o_in_ready is
// high, set by the single read-modify-write of the sum store (one read and
// one write port per cycle); ready drops when the result queue backs up.
// Reset: counters, thresholds and handshake state clear at once; the sum
// store is not swept, a fill mark makes unwritten entries read as zero.
// ---------------------------------------------------------------------------
module averaged_background_subtraction
    import abs_pkg::*;
#(
    parameter int unsigned IMAGE_ROWS   = 240,
    parameter int unsigned IMAGE_COLS   = 320,
    parameter int unsigned LEARN_FRAMES = 10
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // configuration
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    // pixel stream
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  t_pixel_in              i_in_data,
    // mask stream
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output t_mask_out              o_out_data
);

    localparam int unsigned PIXEL_COUNT = IMAGE_ROWS * IMAGE_COLS;
    localparam int unsigned ADDR_W      = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;
    localparam int unsigned FILL_W      = $clog2(PIXEL_COUNT + 1);
    localparam int unsigned FCNT_W      = $clog2(LEARN_FRAMES + 2);

    // floor(x / LEARN_FRAMES) = (x * RECIP) >> RECIP_SHIFT, exact for 12-bit x
    localparam int unsigned RECIP_SHIFT = 17;
    localparam int unsigned RECIP_W     = RECIP_SHIFT + 1;
    localparam int unsigned PROD_W      = SUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(LEARN_FRAMES) - 64'd1) / 64'(LEARN_FRAMES));

    localparam logic [FCNT_W-1:0] FCNT_LEARN = FCNT_W'(LEARN_FRAMES);
    localparam logic [ADDR_W-1:0] ADDR_LAST  = ADDR_W'(PIXEL_COUNT - 1);
    localparam logic [FILL_W-1:0] FILL_FULL  = FILL_W'(PIXEL_COUNT);

    // ---------------- configuration ----------------
    logic [CFG_DATA_W-1:0] r_thr_first;
    logic [CFG_DATA_W-1:0] r_thr_third;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr_first <= THRESHOLD_RESET;
            r_thr_third <= THRESHOLD_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_FIRST_THRESHOLD: r_thr_first <= i_cfg_data;
                CFG_THIRD_THRESHOLD: r_thr_third <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------- input stage: position, frame count, read issue ----------------
    logic              in_fire;
    logic [ADDR_W-1:0] r_pos;
    logic [ADDR_W-1:0] n_pos;
    logic [FCNT_W-1:0] r_frame_cnt;
    logic [FCNT_W-1:0] n_frame_cnt;
    logic [FILL_W-1:0] r_fill;
    logic [FILL_W-1:0] n_fill;
    t_phase            in_phase;

    logic [2:0]        r_q_cnt;
    logic              r_s1_valid;
    logic              out_pop;

    assign out_pop    = o_out_valid && i_out_ready;
    // stage 1 plus a four-entry result queue; three in flight leaves room
    assign o_in_ready = ({2'b00, r_s1_valid} + r_q_cnt) <= 3'd2;
    assign in_fire    = i_in_valid && o_in_ready;

    always_comb begin
        if (r_frame_cnt < FCNT_LEARN) begin
            in_phase = PH_LEARN;
        end else if (r_frame_cnt == FCNT_LEARN) begin
            in_phase = PH_BUILD;
        end else begin
            in_phase = PH_DETECT;
        end
    end

    always_comb begin
        n_pos       = r_pos;
        n_frame_cnt = r_frame_cnt;
        if (in_fire) begin
            if (i_in_data.frame_end) begin
                n_pos = '0;
                if (r_frame_cnt <= FCNT_LEARN) begin
                    n_frame_cnt = r_frame_cnt + 1'b1;
                end
            end else if (r_pos == ADDR_LAST) begin
                n_pos = '0;
            end else begin
                n_pos = r_pos + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_frame_cnt <= '0;
        end else begin
            r_pos       <= n_pos;
            r_frame_cnt <= n_frame_cnt;
        end
    end

    // ---------------- sum / background store ----------------
    // learning: {sum_first, sum_third}; after the build frame: {8'h00, bg_first, bg_third}
    logic [WORD_W-1:0] r_store [PIXEL_COUNT];
    logic [WORD_W-1:0] r_rd_data;
    logic              s1_we;
    logic [WORD_W-1:0] s1_wdata;

    logic [ADDR_W-1:0] r_s1_addr;
    t_phase            r_s1_phase;
    logic [7:0]        r_s1_first;
    logic [7:0]        r_s1_third;
    logic              r_s1_last;
    logic              r_s1_rd_ok;
    logic              r_fwd_hit;
    logic [WORD_W-1:0] r_fwd_data;

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_rd_data <= r_store[r_pos];
        end
        if (s1_we) begin
            r_store[r_s1_addr] <= s1_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_addr  <= r_pos;
            r_s1_phase <= in_phase;
            r_s1_first <= i_in_data.first_channel;
            r_s1_third <= i_in_data.third_channel;
            r_s1_last  <= i_in_data.frame_end;
            r_s1_rd_ok <= FILL_W'(r_pos) < r_fill;
            r_fwd_data <= s1_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_fwd_hit  <= 1'b0;
        end else begin
            r_s1_valid <= in_fire;
            // same entry written this cycle: memory read returns stale data
            r_fwd_hit  <= in_fire && s1_we && (r_s1_addr == r_pos);
        end
    end

    // ---------------- stage 1: modify and write back ----------------
    logic [WORD_W-1:0] s1_word;
    logic [SUM_W-1:0]  sum_first;
    logic [SUM_W-1:0]  sum_third;
    logic [PROD_W-1:0] prod_first;
    logic [PROD_W-1:0] prod_third;
    logic [7:0]        bg_first;
    logic [7:0]        bg_third;
    logic [7:0]        diff_first;
    logic [7:0]        diff_third;
    logic              quiet;
    t_mask_out         s1_result;

    always_comb begin
        if (r_fwd_hit) begin
            s1_word = r_fwd_data;
        end else if (r_s1_rd_ok) begin
            s1_word = r_rd_data;
        end else begin
            s1_word = '0;
        end
    end

    assign sum_first  = s1_word[WORD_W-1:SUM_W];
    assign sum_third  = s1_word[SUM_W-1:0];
    assign prod_first = PROD_W'(sum_first) * PROD_W'(RECIP);
    assign prod_third = PROD_W'(sum_third) * PROD_W'(RECIP);
    assign bg_first   = s1_word[15:8];
    assign bg_third   = s1_word[7:0];
    assign diff_first = (r_s1_first > bg_first) ? (r_s1_first - bg_first)
                                                : (bg_first - r_s1_first);
    assign diff_third = (r_s1_third > bg_third) ? (r_s1_third - bg_third)
                                                : (bg_third - r_s1_third);
    assign quiet      = ({1'b0, diff_first} < r_thr_first) &&
                        ({1'b0, diff_third} < r_thr_third);

    always_comb begin
        s1_we                = 1'b0;
        s1_wdata             = s1_word;
        s1_result.foreground = 1'b0;
        s1_result.mask_valid = 1'b0;
        s1_result.frame_last = r_s1_last;
        case (r_s1_phase)
            PH_LEARN: begin
                s1_we    = r_s1_valid;
                s1_wdata = {sum_first + SUM_W'(r_s1_first),
                            sum_third + SUM_W'(r_s1_third)};
            end
            PH_BUILD: begin
                s1_we    = r_s1_valid;
                s1_wdata = {{(WORD_W - 16){1'b0}},
                            prod_first[RECIP_SHIFT +: 8],
                            prod_third[RECIP_SHIFT +: 8]};
            end
            PH_DETECT: begin
                s1_result.foreground = !quiet;
                s1_result.mask_valid = 1'b1;
            end
            default: ;
        endcase
    end

    // written entries always form a prefix of the raster, so one mark suffices
    always_comb begin
        n_fill = r_fill;
        if (s1_we && (FILL_W'(r_s1_addr) >= r_fill)) begin
            n_fill = FILL_W'(r_s1_addr) + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else begin
            r_fill <= n_fill;
        end
    end

    // ---------------- result queue ----------------
    t_mask_out  r_q [4];
    logic [1:0] r_q_wr;
    logic [1:0] r_q_rd;

    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            r_q[r_q_wr] <= s1_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_wr  <= '0;
            r_q_rd  <= '0;
            r_q_cnt <= '0;
        end else begin
            if (r_s1_valid) begin
                r_q_wr <= r_q_wr + 1'b1;
            end
            if (out_pop) begin
                r_q_rd <= r_q_rd + 1'b1;
            end
            r_q_cnt <= r_q_cnt + {2'b00, r_s1_valid} - {2'b00, out_pop};
        end
    end

    assign o_out_valid = (r_q_cnt != 3'd0);
    assign o_out_data  = r_q[r_q_rd];

`ifndef SYNTHESIS
    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_q_cnt <= 3'd4)
        else $error("result queue over capacity");

    a_no_loss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_q_cnt == 3'd4) |-> out_pop)
        else $error("stage 1 result written into a full queue");

    a_fwd_has_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fwd_hit |-> r_s1_valid)
        else $error("forwarding hit without an item in stage 1");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_FULL)
        else $error("fill mark beyond the store depth");

    a_frame_saturate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_frame_cnt <= FCNT_LEARN + 1'b1)
        else $error("frame count past saturation");
`endif

endmodule
